@@ rtl/prsp_pkg.sv @@
// Package for the response stream parser: phase and context codes, token
// kinds and the token record shared by the parser core, token queue and top.
package prsp_pkg;

  localparam int LEN_BITS_DEF = 32;
  localparam int TOKQ_DEPTH   = 8;
  localparam int MAX_TOK      = 4;

  localparam logic [2:0] PH_TAG   = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_VAL   = 3'd2;
  localparam logic [2:0] PH_SKIPV = 3'd3;
  localparam logic [2:0] PH_SKIPN = 3'd4;
  localparam logic [2:0] PH_BYTES = 3'd5;
  localparam logic [2:0] PH_ERR   = 3'd6;

  localparam logic [2:0] CX_INFO  = 3'd0;
  localparam logic [2:0] CX_DATA  = 3'd1;
  localparam logic [2:0] CX_ENTRY = 3'd2;
  localparam logic [2:0] CX_STR   = 3'd3;
  localparam logic [2:0] CX_TOP   = 3'd4;

  localparam logic [3:0] TK_INFO_BEGIN    = 4'd0;
  localparam logic [3:0] TK_DATA_BEGIN    = 4'd1;
  localparam logic [3:0] TK_KEY_BEGIN     = 4'd2;
  localparam logic [3:0] TK_KEY_BYTE      = 4'd3;
  localparam logic [3:0] TK_VALUE_BEGIN   = 4'd4;
  localparam logic [3:0] TK_VALUE_BYTE    = 4'd5;
  localparam logic [3:0] TK_ENTRY_END     = 4'd6;
  localparam logic [3:0] TK_OK            = 4'd7;
  localparam logic [3:0] TK_STATUS        = 4'd8;
  localparam logic [3:0] TK_TEXT_BEGIN    = 4'd9;
  localparam logic [3:0] TK_TEXT_BYTE     = 4'd10;
  localparam logic [3:0] TK_PAYLOAD_BEGIN = 4'd11;
  localparam logic [3:0] TK_PAYLOAD_BYTE  = 4'd12;
  localparam logic [3:0] TK_DONE          = 4'd13;
  localparam logic [3:0] TK_MSG_OK        = 4'd14;
  localparam logic [3:0] TK_MSG_ERROR     = 4'd15;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [31:0] scalar_value;
    logic [7:0]  data_byte;
    logic        key_present;
    logic        run_last;
  } token_t;

  typedef struct packed {
    logic [2:0] push_n;
    logic       in_error;
  } core_stat_t;

endpackage

@@ rtl/prsp_if.sv @@
// Channel interfaces of the response stream parser: byte requests in,
// token requests out. Depends on nothing.
interface prsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       msg_last;
  modport source (output valid, output in_byte, output msg_last, input ready);
  modport sink   (input valid, input in_byte, input msg_last, output ready);
endinterface

interface prsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [31:0] scalar_value;
  logic [7:0]  data_byte;
  logic        key_present;
  logic        run_last;
  modport source (output valid, output token_kind, output scalar_value,
                  output data_byte, output key_present, output run_last, input ready);
  modport sink   (input valid, input token_kind, input scalar_value,
                  input data_byte, input key_present, input run_last, output ready);
endinterface

@@ rtl/prsp_core.sv @@
// Parser core: varint, nesting stack and token generation for one byte.
// Depends on prsp_pkg.
module prsp_core import prsp_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  logic [7:0]   in_byte,
  input  logic         msg_last,
  output token_t       tok [MAX_TOK],
  output core_stat_t   stat
);

  logic [2:0]          phase_r, phase_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic [3:0]          sh_r, sh_nxt;
  logic [31:0]         fld_r, fld_nxt;
  logic [2:0]          wire_r, wire_nxt;
  logic [1:0]          dep_r, dep_nxt;
  logic [LEN_BITS-1:0] rem_r [3];
  logic [LEN_BITS-1:0] rem_nxt [3];
  logic [1:0]          cx_r [3];
  logic [1:0]          cx_nxt [3];
  logic [LEN_BITS-1:0] skip_r, skip_nxt;
  logic                key_r, key_nxt;

  logic [2:0] n;
  logic       bad;

  always_comb begin
    logic [70:0] wide;
    logic [63:0] accw;
    logic [63:0] v;
    logic [31:0] f;
    logic [2:0]  w;
    logic [2:0]  ctx;
    logic [2:0]  parent;
    logic [2:0]  ck;
    logic [3:0]  beg;
    logic        kv, kl, strict, stop;
    logic [1:0]  d;
    phase_nxt = phase_r; acc_nxt = acc_r; sh_nxt = sh_r; fld_nxt = fld_r;
    wire_nxt = wire_r; dep_nxt = dep_r; rem_nxt = rem_r; cx_nxt = cx_r;
    skip_nxt = skip_r; key_nxt = key_r;
    for (int i = 0; i < MAX_TOK; i++) tok[i] = '0;
    n = 3'd0; bad = 1'b0; stop = 1'b0;
    wide = 71'(in_byte[6:0]) << (7 * sh_r);
    accw = acc_r | wide[63:0];
    v = accw;
    f = accw[34:3];
    w = accw[2:0];
    kv = 1'b0; kl = 1'b0; beg = TK_MSG_ERROR;
    ctx = (dep_r == 2'd0) ? CX_TOP : {1'b0, cx_r[dep_r - 2'd1]};
    parent = (dep_r >= 2'd2) ? {1'b0, cx_r[dep_r - 2'd2]} : CX_TOP;
    strict = (ctx != CX_ENTRY);
    d = 2'd0; ck = CX_TOP;

    if (phase_r == PH_ERR) begin
      n = 3'd0;
    end else begin
      for (int i = 0; i < 3; i++)
        if (2'(i) < dep_r && rem_r[i] != '0) rem_nxt[i] = rem_r[i] - 1'b1;

      case (phase_r)
        PH_TAG, PH_LEN, PH_VAL, PH_SKIPV: begin
          if (in_byte[7]) begin
            acc_nxt = accw;
            sh_nxt = sh_r + 4'd1;
            if (sh_r == 4'd9) bad = 1'b1;
          end else begin
            acc_nxt = '0;
            sh_nxt = 4'd0;
            phase_nxt = PH_TAG;
            if (phase_r == PH_TAG) begin
              fld_nxt = f;
              wire_nxt = w;
              if (ctx == CX_TOP) begin
                kl = (f == 32'd1) || (f == 32'd2);
              end else if (ctx == CX_INFO) begin
                kl = (f == 32'd1) || (f == 32'd5);
                kv = (f == 32'd2) || (f == 32'd4);
              end else if (ctx == CX_DATA) begin
                kl = (f == 32'd1);
                kv = (f == 32'd2);
              end
              if (w == 3'd0) begin
                if (kv) phase_nxt = PH_VAL;
                else if (kl && strict) bad = 1'b1;
                else phase_nxt = PH_SKIPV;
              end else if (w == 3'd2) begin
                if (kv && strict) bad = 1'b1;
                else phase_nxt = PH_LEN;
              end else if (w == 3'd1 || w == 3'd5) begin
                if ((kv || kl) && strict) bad = 1'b1;
                else begin
                  skip_nxt = (w == 3'd1) ? LEN_BITS'(8) : LEN_BITS'(4);
                  phase_nxt = PH_SKIPN;
                end
              end else begin
                bad = 1'b1;
              end
            end else if (phase_r == PH_LEN) begin
              if ((v >> LEN_BITS) != 64'd0) bad = 1'b1;
              else if (dep_r != 2'd0 && v > 64'(rem_nxt[dep_r - 2'd1])) bad = 1'b1;
              else if (ctx == CX_TOP && (fld_r == 32'd1 || fld_r == 32'd2)) begin
                tok[0].token_kind = (fld_r == 32'd1) ? TK_INFO_BEGIN : TK_DATA_BEGIN;
                n = 3'd1;
                if (v != 64'd0 && dep_r != 2'd3) begin
                  rem_nxt[dep_r] = v[LEN_BITS-1:0];
                  cx_nxt[dep_r] = (fld_r == 32'd1) ? CX_INFO[1:0] : CX_DATA[1:0];
                  dep_nxt = dep_r + 2'd1;
                end
              end else if (ctx == CX_INFO && fld_r == 32'd1) begin
                if (v != 64'd0) begin
                  key_nxt = 1'b0;
                  if (dep_r != 2'd3) begin
                    rem_nxt[dep_r] = v[LEN_BITS-1:0];
                    cx_nxt[dep_r] = CX_ENTRY[1:0];
                    dep_nxt = dep_r + 2'd1;
                  end
                end else begin
                  tok[0].token_kind = TK_ENTRY_END;
                  n = 3'd1;
                end
              end else begin
                if (ctx == CX_INFO && fld_r == 32'd5) beg = TK_TEXT_BEGIN;
                else if (ctx == CX_DATA && fld_r == 32'd1) beg = TK_PAYLOAD_BEGIN;
                else if (ctx == CX_ENTRY && fld_r == 32'd1) begin
                  beg = TK_KEY_BEGIN;
                  key_nxt = (v != 64'd0);
                end else if (ctx == CX_ENTRY && fld_r == 32'd2) beg = TK_VALUE_BEGIN;
                if (beg != TK_MSG_ERROR) begin
                  tok[0].token_kind = beg;
                  n = 3'd1;
                  if (v != 64'd0) begin
                    if (dep_r != 2'd3) begin
                      rem_nxt[dep_r] = v[LEN_BITS-1:0];
                      cx_nxt[dep_r] = CX_STR[1:0];
                      dep_nxt = dep_r + 2'd1;
                    end
                    phase_nxt = PH_BYTES;
                  end
                end else begin
                  skip_nxt = v[LEN_BITS-1:0];
                  if (v != 64'd0) phase_nxt = PH_SKIPN;
                end
              end
            end else if (phase_r == PH_VAL) begin
              n = 3'd1;
              if (ctx == CX_INFO && fld_r == 32'd4) begin
                tok[0].token_kind = TK_STATUS;
                tok[0].scalar_value = v[31:0];
              end else begin
                tok[0].token_kind = (ctx == CX_DATA) ? TK_DONE : TK_OK;
                tok[0].scalar_value = {31'd0, v != 64'd0};
              end
            end
          end
        end
        PH_SKIPN: begin
          if (skip_r != '0) skip_nxt = skip_r - 1'b1;
          if (skip_nxt == '0) phase_nxt = PH_TAG;
        end
        PH_BYTES: begin
          n = 3'd1;
          tok[0].data_byte = in_byte;
          if (parent == CX_ENTRY)
            tok[0].token_kind = (fld_r == 32'd1) ? TK_KEY_BYTE : TK_VALUE_BYTE;
          else if (parent == CX_INFO) tok[0].token_kind = TK_TEXT_BYTE;
          else tok[0].token_kind = TK_PAYLOAD_BYTE;
        end
        default: bad = 1'b1;
      endcase

      // close finished regions, innermost first
      d = dep_nxt;
      for (int k = 0; k < 3; k++) begin
        if (!bad && !stop && d != 2'd0 && rem_nxt[d - 2'd1] == '0) begin
          ck = {1'b0, cx_nxt[d - 2'd1]};
          if (ck == CX_STR) begin
            if (phase_nxt != PH_BYTES) bad = 1'b1;
            else phase_nxt = PH_TAG;
          end else if (phase_nxt != PH_TAG || sh_nxt != 4'd0) begin
            bad = 1'b1;
          end else if (ck == CX_ENTRY) begin
            tok[n[1:0]] = '0;
            tok[n[1:0]].token_kind = TK_ENTRY_END;
            tok[n[1:0]].key_present = key_nxt;
            n = n + 3'd1;
          end
          if (!bad) d = d - 2'd1;
        end else begin
          stop = 1'b1;
        end
      end
      dep_nxt = d;

      if (bad) begin
        for (int i = 0; i < MAX_TOK; i++) tok[i] = '0;
        tok[0].token_kind = TK_MSG_ERROR;
        n = 3'd1;
        if (!msg_last) phase_nxt = PH_ERR;
      end else if (msg_last) begin
        tok[n[1:0]] = '0;
        tok[n[1:0]].token_kind =
          (dep_nxt == 2'd0 && phase_nxt == PH_TAG && sh_nxt == 4'd0) ?
          TK_MSG_OK : TK_MSG_ERROR;
        n = n + 3'd1;
      end
      if (n != 3'd0) tok[n[1:0] - 2'd1].run_last = 1'b1;
    end

    // restart at message end
    if (msg_last) begin
      phase_nxt = PH_TAG; acc_nxt = '0; sh_nxt = 4'd0; fld_nxt = '0;
      wire_nxt = 3'd0; dep_nxt = 2'd0; skip_nxt = '0; key_nxt = 1'b0;
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = '0;
        cx_nxt[i] = 2'd0;
      end
    end
  end

  assign stat.push_n = fire ? n : 3'd0;
  assign stat.in_error = (phase_r == PH_ERR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG; acc_r <= '0; sh_r <= 4'd0; fld_r <= '0;
      wire_r <= 3'd0; dep_r <= 2'd0; skip_r <= '0; key_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= '0;
        cx_r[i] <= 2'd0;
      end
    end else if (fire) begin
      phase_r <= phase_nxt; acc_r <= acc_nxt; sh_r <= sh_nxt; fld_r <= fld_nxt;
      wire_r <= wire_nxt; dep_r <= dep_nxt; skip_r <= skip_nxt; key_r <= key_nxt;
      rem_r <= rem_nxt;
      cx_r <= cx_nxt;
    end
  end

endmodule

@@ rtl/prsp_tok_fifo.sv @@
// Token queue: takes up to four tokens a cycle, hands out one.
// Depends on prsp_pkg.
module prsp_tok_fifo import prsp_pkg::*; #(
  parameter int DEPTH = TOKQ_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  token_t                 tok [MAX_TOK],
  input  logic [2:0]             push_n,
  input  logic                   pop,
  output token_t                 head,
  output logic [$clog2(DEPTH):0] count
);

  localparam int AW = $clog2(DEPTH);

  token_t                mem [DEPTH];
  logic [AW-1:0]         wr_r, rd_r;
  logic [AW:0]           cnt_r;

  assign head  = mem[rd_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_TOK; k++)
      if (3'(k) < push_n) mem[wr_r + AW'(k)] <= tok[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_r + AW'(push_n);
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push_n) - (AW+1)'(pop);
    end
  end

endmodule

@@ rtl/protobuf_response_stream_parser_unit.sv @@
// Top level of the response stream parser: parser core feeding a token queue.
// Depends on prsp_pkg, prsp_if, prsp_core and prsp_tok_fifo.
//
//  channel  | dir | payload                                          | handshake
//  in_ch    | in  | in_byte, msg_last                                | valid/ready
//  out_ch   | out | token_kind, scalar_value, data_byte, key_present,| valid/ready
//           |     | run_last                                         |
//
// One byte per cycle: each byte is parsed in the cycle it is taken and its
// zero to three tokens land in an eight-entry queue; one token leaves a cycle.
// A byte is taken while the queue has room for four tokens, so a stalled
// output holds back input once more than four tokens wait.
// Reset (synchronous, rst_n low) empties the queue and puts the parser at a tag.
module protobuf_response_stream_parser_unit import prsp_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  prsp_in_if.sink   in_ch,
  prsp_out_if.source out_ch
);

  localparam int QW = $clog2(TOKQ_DEPTH);

  token_t      tok [MAX_TOK];
  token_t      head;
  core_stat_t  stat;
  logic [QW:0] count;
  logic        fire, pop;

  assign in_ch.ready = (count <= (QW+1)'(TOKQ_DEPTH - MAX_TOK));
  assign fire = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (count != '0);
  assign pop = out_ch.valid && out_ch.ready;

  assign out_ch.token_kind   = head.token_kind;
  assign out_ch.scalar_value = head.scalar_value;
  assign out_ch.data_byte    = head.data_byte;
  assign out_ch.key_present  = head.key_present;
  assign out_ch.run_last     = head.run_last;

  prsp_core #(.LEN_BITS(LEN_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .fire(fire),
    .in_byte(in_ch.in_byte), .msg_last(in_ch.msg_last),
    .tok(tok), .stat(stat)
  );

  prsp_tok_fifo #(.DEPTH(TOKQ_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .tok(tok), .push_n(stat.push_n),
    .pop(pop), .head(head), .count(count)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count <= (QW+1)'(TOKQ_DEPTH))
    else $error("token queue overflow");

  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    stat.in_error |-> stat.push_n == 3'd0)
    else $error("tokens emitted while skipping a bad message");

  a_push_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.push_n <= 3'(MAX_TOK))
    else $error("too many tokens for one byte");

  a_empty_after_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_ch.valid)
    else $error("queue not empty after reset");

endmodule
